// ===== hw/rtl/rfd_pkg.sv =====
// Shared types, constants and helper functions for the run-length frame decoder.
// No dependencies; rfd_step and the core import this package, while rfd_if.sv does not.
package rfd_pkg;

    localparam int unsigned POS_W   = 13;
    localparam int unsigned COUNT_W = 15;

    localparam logic [POS_W-1:0] FRAME_BYTES = 13'd4800;

    // Decoder phase codes.
    localparam logic [1:0] PH_HDR_HI = 2'd0;
    localparam logic [1:0] PH_HDR_LO = 2'd1;
    localparam logic [1:0] PH_LITERAL = 2'd2;
    localparam logic [1:0] PH_REPEAT = 2'd3;

    localparam logic [7:0] LITERAL_FLAG = 8'h80;
    localparam logic [7:0] HI_COUNT_MASK = 8'h7F;

    typedef struct packed {
        logic [1:0]         phase;
        logic               literal_mode;
        logic [COUNT_W-1:0] count_left;
        logic [POS_W-1:0]   write_pos;
        logic               overrun_pending;
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [7:0]         pixel_value;
        logic [COUNT_W-1:0] run_length;
        logic [POS_W-1:0]   run_start;
        logic [31:0]        display_word;
        logic               frame_done;
        logic               overrun;
    } result_t;

    // Each pixel pair of the value becomes one display byte: the upper bit of the
    // pair sets 0x18 and the lower bit sets 0xC0.
    function automatic logic [31:0] spread_display(input logic [7:0] v);
        logic [31:0] w;
        w = '0;
        for (int k = 0; k < 4; k++) begin
            w[31-8*k -: 8] = (v[7-2*k] ? 8'h18 : 8'h00) | (v[6-2*k] ? 8'hC0 : 8'h00);
        end
        return w;
    endfunction

endpackage

// ===== hw/rtl/rfd_if.sv =====
// Valid/ready channel interfaces for the run-length frame decoder.
// Depends on nothing; carries the compressed byte stream and the run descriptors.
interface rfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface

interface rfd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_value;
    logic [14:0] run_length;
    logic [12:0] run_start;
    logic [31:0] display_word;
    logic        frame_done;
    logic        overrun;

    modport source (output valid, output pixel_value, output run_length, output run_start,
                    output display_word, output frame_done, output overrun, input ready);
    modport sink (input valid, input pixel_value, input run_length, input run_start,
                  input display_word, input frame_done, input overrun, output ready);
endinterface

// ===== hw/rtl/rfd_step.sv =====
// Next-state and result logic for one compressed byte of the frame decoder.
// Depends on rfd_pkg for the state and result structs and the phase codes.
module rfd_step (
    input  rfd_pkg::state_t  cur,
    input  logic [7:0]       code_byte,
    output rfd_pkg::state_t  nxt,
    output rfd_pkg::result_t res
);
    import rfd_pkg::*;

    logic [POS_W-1:0]   space;
    logic [COUNT_W-1:0] hdr_count;
    logic [COUNT_W-1:0] space_ext;
    logic [COUNT_W-1:0] cnt_dec;
    logic [COUNT_W-1:0] rep_len;
    logic [POS_W-1:0]   lit_pos;
    logic [POS_W:0]     rep_sum;
    logic [POS_W-1:0]   rep_pos;
    logic               in_frame;

    always_comb
    begin
        in_frame  = cur.write_pos < FRAME_BYTES;
        space     = in_frame ? (FRAME_BYTES - cur.write_pos) : '0;
        space_ext = COUNT_W'(space);
        hdr_count = {cur.count_left[6:0], code_byte};
        cnt_dec   = (cur.count_left != '0) ? (cur.count_left - 1'b1) : '0;
        rep_len   = (cur.count_left > space_ext) ? space_ext : cur.count_left;
        lit_pos   = cur.write_pos + 1'b1;
        // The clamped length never exceeds the free space, so the sum stays in the frame.
        rep_sum   = {1'b0, cur.write_pos} + {1'b0, rep_len[POS_W-1:0]};
        rep_pos   = rep_sum[POS_W-1:0];

        nxt = cur;
        res = '0;
        res.pixel_value  = code_byte;
        res.display_word = spread_display(code_byte);
        res.overrun      = cur.overrun_pending;

        case (cur.phase)
            PH_HDR_HI:
            begin
                nxt.literal_mode = (code_byte & LITERAL_FLAG) != 8'h00;
                nxt.count_left   = COUNT_W'(code_byte & HI_COUNT_MASK);
                nxt.phase        = PH_HDR_LO;
            end
            PH_HDR_LO:
            begin
                nxt.count_left      = hdr_count;
                nxt.overrun_pending = hdr_count > space_ext;
                if (!cur.literal_mode)
                begin
                    nxt.phase = PH_REPEAT;
                end
                else if (hdr_count != '0)
                begin
                    nxt.phase = PH_LITERAL;
                end
                else
                begin
                    nxt.phase = PH_HDR_HI;
                    if (!in_frame)
                    begin
                        nxt.write_pos = '0;
                    end
                end
            end
            PH_LITERAL:
            begin
                nxt.count_left = cnt_dec;
                if (in_frame)
                begin
                    res.valid      = 1'b1;
                    res.run_length = COUNT_W'(1);
                    res.run_start  = cur.write_pos;
                    res.frame_done = lit_pos == FRAME_BYTES;
                    nxt.write_pos  = lit_pos;
                end
                if (cnt_dec == '0)
                begin
                    nxt.phase = PH_HDR_HI;
                    if (!in_frame || lit_pos == FRAME_BYTES)
                    begin
                        nxt.write_pos = '0;
                    end
                end
            end
            default:
            begin
                // Repeat value byte: one descriptor for the whole clamped run.
                nxt.count_left = '0;
                nxt.phase      = PH_HDR_HI;
                if (rep_len != '0)
                begin
                    res.valid      = 1'b1;
                    res.run_length = rep_len;
                    res.run_start  = cur.write_pos;
                    res.frame_done = rep_pos == FRAME_BYTES;
                    nxt.write_pos  = (rep_pos == FRAME_BYTES) ? '0 : rep_pos;
                end
                else if (!in_frame)
                begin
                    nxt.write_pos = '0;
                end
            end
        endcase
    end

endmodule

// ===== hw/rtl/rle_frame_decoder_core.sv =====
// Top level of the run-length frame decoder: input register, decode step, result register.
// Depends on rfd_pkg, the channel interfaces in rfd_if.sv and the rfd_step module.

// Takes one compressed byte per transfer on code_in and emits one run descriptor on run_out
// for every literal byte that lands in the 4800-byte frame and for every nonempty repeat run.
// Each run opens with a two-byte header, high byte first; bit 7 of the high byte selects a
// literal run, and the other 15 bits give the count. Runs that pass the frame end are
// clamped and flagged with overrun, and the frame restarts at offset 0 after the run that fills it.
// The block sustains one byte per cycle while run_out takes its results: a byte is held in
// the input register, decoded by a single pass of compare-and-add logic, and its descriptor
// is registered in the result register. The only stall is a result not yet taken on run_out.
module rle_frame_decoder_core (
    input logic clk,
    input logic rst_n,
    rfd_in_if.sink    code_in,
    rfd_out_if.source run_out
);
    import rfd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    step_res;
    result_t    out_reg;
    logic       advance;

    // The staged byte moves on when the result register is free or being emptied.
    assign advance       = in_valid_reg && (!out_reg.valid || run_out.ready);
    assign code_in.ready = !in_valid_reg || advance;

    rfd_step u_step (
        .cur       (state_reg),
        .code_byte (in_byte_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
            out_reg      <= '0;
        end
        else
        begin
            if (code_in.ready)
            begin
                in_valid_reg <= code_in.valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
                out_reg   <= step_res;
            end
            else if (run_out.ready)
            begin
                out_reg.valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (code_in.valid && code_in.ready)
        begin
            in_byte_reg <= code_in.code_byte;
        end
    end

    assign run_out.valid        = out_reg.valid;
    assign run_out.pixel_value  = out_reg.pixel_value;
    assign run_out.run_length   = out_reg.run_length;
    assign run_out.run_start    = out_reg.run_start;
    assign run_out.display_word = out_reg.display_word;
    assign run_out.frame_done   = out_reg.frame_done;
    assign run_out.overrun      = out_reg.overrun;

endmodule
